/* design/esu_pkg.sv */
// ----------------------------------------------------------------------------
// esu_pkg: shared types and constants of the escape sequence unescaper
// Result kinds, result and per-item bundle structs, character codes and the
// hex digit decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package esu_pkg;

  localparam int POS_W   = 16;  // width of the in-string byte position
  localparam int ERR_W   = 16;  // width of the reported error position
  localparam int MAX_RES = 3;   // most results one item can cause
  localparam int CNT_W   = 2;   // holds 0 .. MAX_RES

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       data;
    logic [ERR_W-1:0] err_pos;
    logic             last;
  } res_t;

  // all results caused by one item, in delivery order from index 0
  typedef struct packed {
    logic [CNT_W-1:0]   cnt;
    res_t [MAX_RES-1:0] res;
  } step_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // {valid, value} of a hex digit in either case
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // lowercase-only digit test used right after a backslash
  function automatic logic is_lower_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66);
  endfunction

endpackage

`default_nettype wire

/* design/escape_sequence_unescaper.sv */
// ----------------------------------------------------------------------------
// escape_sequence_unescaper: backslash escape decoder with UTF-8 output
// Pipeline: an accepted byte waits in the input register, is decoded
//   combinationally and loads its results into the result register.
// Throughput: 1 byte per cycle while the result register has room; a \uHHHH
//   escape that encodes to 2 or 3 bytes holds the input while the result
//   register drains, one result per cycle when the output does not stall.
// Reset: synchronous, active low; clears parse state and position to the
//   start of a string in normal text mode and empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_sequence_unescaper import esu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  // input channel: one string byte per item
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_ch,
  // result channel
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_out_byte,
  output logic [ERR_W-1:0] out_error_pos,
  output logic             out_last_of_run
);

  // input register: holds one accepted byte until the result register has room
  logic       in_vld_r;
  logic [7:0] in_ch_r;

  logic       buf_free;
  logic       load;
  step_t      step_res;

  // advance the held byte whenever its results can be loaded; a byte that
  // causes no results still advances the parse state the same way
  assign load     = in_vld_r && buf_free;
  // hold the input only while a held byte waits for room
  assign in_stall = in_vld_r && !buf_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  // payload needs no reset; it is qualified by in_vld_r
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_ch_r <= in_ch;
    end
  end

  // decode: parse state plus short logic from the held byte to results
  esu_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (load),
    .ch     (in_ch_r),
    .step_o (step_res)
  );

  // result register: drain the item's results one per handshake
  esu_outbuf u_outbuf (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (load),
    .step_i          (step_res),
    .free            (buf_free),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kind        (out_kind),
    .out_out_byte    (out_out_byte),
    .out_error_pos   (out_error_pos),
    .out_last_of_run (out_last_of_run)
  );

  a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r)
    else $error("input stalled with nothing held");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_DONE || out_kind == KIND_ERROR) |-> out_last_of_run)
    else $error("end or error result not marked last");

  a_held_byte_moves: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !out_valid |-> !in_stall)
    else $error("held byte blocked while result register empty");

endmodule

`default_nettype wire

/* design/esu_core.sv */
// ----------------------------------------------------------------------------
// esu_core: escape decoder state and per-item decode
// Holds the parse state and turns one byte into up to three results.
// ----------------------------------------------------------------------------
`default_nettype none

module esu_core import esu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,     // commit the decode of ch
  input  logic [7:0] ch,
  output step_t      step_o
);

  typedef enum logic [2:0] {
    M_NORMAL  = 3'd0,
    M_ESC     = 3'd1,
    M_HEX2    = 3'd2,
    M_UNI     = 3'd3,
    M_DISCARD = 3'd4
  } mode_t;

  mode_t            mode_r, mode_nxt;
  logic [2:0]       digits_r, digits_nxt;
  logic             stopped_r, stopped_nxt;
  logic [15:0]      acc_r, acc_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] esc_r, esc_nxt;

  logic [4:0]       hv;
  logic [15:0]      cp;
  logic [2:0]       dig_inc;
  logic             ended;
  logic [CNT_W-1:0] cnt;
  res_t [MAX_RES-1:0] res;

  function automatic res_t mk(input kind_t k, input logic [7:0] d,
                              input logic [ERR_W-1:0] e);
    res_t r;
    r.kind    = k;
    r.data    = d;
    r.err_pos = e;
    r.last    = 1'b0;
    return r;
  endfunction

  assign hv      = hex_digit(ch);
  assign dig_inc = digits_r + 3'd1;
  assign cp      = (!stopped_r && hv[4]) ? {acc_r[11:0], hv[3:0]} : acc_r;

  always_comb begin
    mode_nxt    = mode_r;
    digits_nxt  = digits_r;
    stopped_nxt = stopped_r;
    acc_nxt     = acc_r;
    esc_nxt     = esc_r;
    ended       = 1'b0;
    cnt         = '0;
    res         = '0;

    case (mode_r)
      M_ESC: begin
        mode_nxt = M_NORMAL;
        if (ch == CH_NUL) begin
          res[0] = mk(KIND_ERROR, 8'd0, ERR_W'(esc_r));
          cnt    = CNT_W'(1);
          ended  = 1'b1;
        end else if (ch == CH_R) begin
          res[0] = mk(KIND_BYTE, CH_CR, '0);
          cnt    = CNT_W'(1);
        end else if (ch == CH_N) begin
          res[0] = mk(KIND_BYTE, CH_LF, '0);
          cnt    = CNT_W'(1);
        end else if (ch == CH_T) begin
          res[0] = mk(KIND_BYTE, CH_TAB, '0);
          cnt    = CNT_W'(1);
        end else if (ch == CH_BSL || ch == CH_QUOTE) begin
          res[0] = mk(KIND_BYTE, ch, '0);
          cnt    = CNT_W'(1);
        end else if (is_lower_hex(ch)) begin
          acc_nxt  = {12'd0, hv[3:0]};
          mode_nxt = M_HEX2;
        end else if (ch == CH_U) begin
          acc_nxt     = '0;
          digits_nxt  = '0;
          stopped_nxt = 1'b0;
          mode_nxt    = M_UNI;
        end else begin
          res[0]   = mk(KIND_ERROR, 8'd0, ERR_W'(esc_r));
          cnt      = CNT_W'(1);
          mode_nxt = M_DISCARD;
        end
      end
      M_HEX2: begin
        if (ch == CH_NUL) begin
          res[0] = mk(KIND_ERROR, 8'd0, ERR_W'(esc_r));
          cnt    = CNT_W'(1);
          ended  = 1'b1;
        end else begin
          if (hv[4]) begin
            acc_nxt = {8'd0, acc_r[3:0], hv[3:0]};
          end
          res[0]   = mk(KIND_BYTE, hv[4] ? {acc_r[3:0], hv[3:0]} : acc_r[7:0], '0);
          cnt      = CNT_W'(1);
          mode_nxt = M_NORMAL;
        end
      end
      M_UNI: begin
        if (ch == CH_NUL) begin
          res[0] = mk(KIND_ERROR, 8'd0, ERR_W'(esc_r));
          cnt    = CNT_W'(1);
          ended  = 1'b1;
        end else begin
          acc_nxt     = cp;
          stopped_nxt = stopped_r | ~hv[4];
          digits_nxt  = dig_inc;
          if (dig_inc[2]) begin
            if (cp[15:7] == '0) begin
              res[0] = mk(KIND_BYTE, cp[7:0], '0);
              cnt    = CNT_W'(1);
            end else if (cp[15:11] == '0) begin
              res[0] = mk(KIND_BYTE, {3'b110, cp[10:6]}, '0);
              res[1] = mk(KIND_BYTE, {2'b10, cp[5:0]}, '0);
              cnt    = CNT_W'(2);
            end else begin
              res[0] = mk(KIND_BYTE, {4'b1110, cp[15:12]}, '0);
              res[1] = mk(KIND_BYTE, {2'b10, cp[11:6]}, '0);
              res[2] = mk(KIND_BYTE, {2'b10, cp[5:0]}, '0);
              cnt    = CNT_W'(3);
            end
            digits_nxt  = '0;
            stopped_nxt = 1'b0;
            mode_nxt    = M_NORMAL;
          end
        end
      end
      M_DISCARD: begin
        ended = (ch == CH_NUL);
      end
      default: begin
        if (ch == CH_NUL) begin
          res[0] = mk(KIND_DONE, 8'd0, '0);
          cnt    = CNT_W'(1);
          ended  = 1'b1;
        end else if (ch == CH_BSL) begin
          esc_nxt  = pos_r;
          mode_nxt = M_ESC;
        end else begin
          res[0]   = mk(KIND_BYTE, ch, '0);
          cnt      = CNT_W'(1);
          mode_nxt = M_NORMAL;
        end
      end
    endcase

    // flag the final result of this item
    for (int i = 0; i < MAX_RES; i++) begin
      res[i].last = (cnt == CNT_W'(i + 1));
    end

    if (ended) begin
      mode_nxt    = M_NORMAL;
      digits_nxt  = '0;
      stopped_nxt = 1'b0;
      acc_nxt     = '0;
      esc_nxt     = '0;
      pos_nxt     = '0;
    end else begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  assign step_o.cnt = cnt;
  assign step_o.res = res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= M_NORMAL;
      digits_r  <= '0;
      stopped_r <= 1'b0;
      acc_r     <= '0;
      pos_r     <= '0;
      esc_r     <= '0;
    end else if (step) begin
      mode_r    <= mode_nxt;
      digits_r  <= digits_nxt;
      stopped_r <= stopped_nxt;
      acc_r     <= acc_nxt;
      pos_r     <= pos_nxt;
      esc_r     <= esc_nxt;
    end
  end

  a_uni_counters_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != M_UNI |-> digits_r == 3'd0 && !stopped_r)
    else $error("unicode digit counters not cleared outside \\u escape");

  a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    step && ch == CH_NUL && mode_r != M_ESC |=> pos_r == '0)
    else $error("position not restarted after end of string");

  a_plain_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    step && mode_r == M_NORMAL && ch != CH_BSL |-> step_o.cnt == CNT_W'(1))
    else $error("plain byte did not give exactly one result");

endmodule

`default_nettype wire

/* design/esu_outbuf.sv */
// ----------------------------------------------------------------------------
// esu_outbuf: result register for one item's results
// Loads up to three results at once and delivers them one per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module esu_outbuf import esu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  step_t            step_i,
  output logic             free,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_kind,
  output logic [7:0]       out_out_byte,
  output logic [ERR_W-1:0] out_error_pos,
  output logic             out_last_of_run
);

  logic [CNT_W-1:0] cnt_r;
  res_t             res_r [MAX_RES];
  logic             pop;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  // room for a new item once the last pending result leaves
  assign free      = (cnt_r == '0) || (cnt_r == CNT_W'(1) && !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= step_i.cnt;
    end else if (pop) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_RES; i++) begin
        res_r[i] <= step_i.res[i];
      end
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        res_r[i] <= res_r[i+1];
      end
    end
  end

  assign out_kind        = res_r[0].kind;
  assign out_out_byte    = res_r[0].data;
  assign out_error_pos   = res_r[0].err_pos;
  assign out_last_of_run = res_r[0].last;

  a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == CNT_W'(1) |-> res_r[0].last)
    else $error("final pending result lacks last flag");

  a_no_early_last: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r > CNT_W'(1) |-> !res_r[0].last)
    else $error("last flag before final result");

  a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> cnt_r == $past(step_i.cnt))
    else $error("result count not taken on load");

endmodule

`default_nettype wire
